### design/blc_pkg.sv
// Shared types and constants for the lookahead cache unit.
package blc_pkg;

  localparam logic CMD_ACCESS = 1'b0;
  localparam logic CMD_DRAIN  = 1'b1;

  localparam int REG_BLOCK_SHIFT   = 0;
  localparam int REG_WINDOW_LENGTH = 1;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 11;
  localparam int CNT_W      = 48;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_SCAN,
    ST_LOOK,
    ST_EMIT
  } state_t;

  // Control for the window shift chain.
  typedef struct packed {
    logic push;
    logic pop;
  } chain_ctl_t;

endpackage

### design/blc_cell.sv
// One window cell: holds an entry and compares it with a probe block.
module blc_cell
  import blc_pkg::*;
#(
  parameter int AW = 48
) (
  input  logic          clk,
  input  logic          load,
  input  logic [AW-1:0] load_val,
  input  logic [AW-1:0] probe,
  output logic [AW-1:0] value,
  output logic          match
);

  logic [AW-1:0] val_r;

  always_ff @(posedge clk) begin
    if (load) begin
      val_r <= load_val;
    end
  end

  assign value = val_r;
  assign match = (val_r == probe);

endmodule

### design/belady_lookahead_cache_unit.sv
// Top level of the Belady lookahead cache unit.
//
// The unit takes a request on start while busy is low, and every request
// that yields a result shows it on the out_ ports for one cycle with
// out_valid high; the receiver cannot stall, so results are never held.
// The lookahead window is a row of cells that shifts toward the head: the
// oldest entry sits in cell zero and a pop moves every cell one place down.
// A request that looks a block up goes through a sequence of steps after
// it is accepted: shift the chain and read the set's tag row (the row is
// registered), then one check-and-scan step per way until the set is known
// to hit, to have a free way, or to have a victim (all cells compare at once,
// a priority search picks the nearest use; the scan stops early at a way
// whose block is absent from the window), update tags and counters, and
// emit. The result is on the ports in the cycle after the emit cycle, which
// is also the first cycle a new request can be taken. A lookup that hits or
// finds a free way ends its scan at the first way, one that must pick a
// victim may scan every way; an access that only fills the window returns to
// idle after the shift, and a drain of an empty window goes from the shift
// straight to the emit. Tags are kept in a per-set memory that holds every
// way of a set in one row, with per-line valid bits cleared at reset.
module belady_lookahead_cache_unit
  import blc_pkg::*;
#(
  parameter int SET_COUNT    = 64,
  parameter int WAYS         = 2,
  parameter int WINDOW_DEPTH = 1024,
  parameter int ADDRESS_BITS = 48
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic                  in_command,
  input  logic [47:0]           in_byte_address,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output logic                  out_valid,
  output logic [47:0]           out_processed_block,
  output logic                  out_hit,
  output logic                  out_way_used,
  output logic                  out_window_empty,
  output logic [CNT_W-1:0]      out_hit_count,
  output logic [CNT_W-1:0]      out_miss_count
);

  localparam int AW   = ADDRESS_BITS;
  localparam int SETB = (SET_COUNT > 1) ? $clog2(SET_COUNT) : 1;
  localparam int WB   = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int DB   = $clog2(WINDOW_DEPTH + 1);
  localparam int DIST = $clog2(WINDOW_DEPTH + 2);
  localparam int TAGW = AW;
  localparam int RW   = WAYS * TAGW;
  localparam int LINES = SET_COUNT * WAYS;
  localparam int LB   = (LINES > 1) ? $clog2(LINES) : 1;

  state_t state_r, state_nxt;

  logic [3:0]   block_shift_r;
  logic [10:0]  window_length_r;
  logic [DB-1:0] fill_r;
  logic [CNT_W-1:0] hits_r, misses_r;

  logic          cmd_r;
  logic [AW-1:0] blk_r;     // new block from an access
  logic [AW-1:0] cur_r;     // block being looked up
  logic          look_r;    // a lookup follows
  logic          push_r;    // new block goes into the window
  logic          empty_r;

  logic [RW-1:0]    tag_mem [SET_COUNT];
  logic [RW-1:0]    row_r;
  logic [LINES-1:0] valid_r;

  logic [WB-1:0]   scan_way_r;
  logic [WB-1:0]   pick_r;
  logic [DIST-1:0] far_r;
  logic            found_far_r;

  logic          hit_r, way_hit_r;
  logic [WB-1:0] way_r;

  // Effective length, the smaller of the register and the depth.
  logic [DIST-1:0] eff_len;
  always_comb begin
    if ({{(32-11){1'b0}}, window_length_r} > WINDOW_DEPTH) begin
      eff_len = DIST'(WINDOW_DEPTH);
    end else begin
      eff_len = DIST'(window_length_r);
    end
  end

  // Cell chain.
  logic [AW-1:0] cell_val [WINDOW_DEPTH];
  logic          cell_match [WINDOW_DEPTH];
  logic          cell_load [WINDOW_DEPTH];
  logic [AW-1:0] cell_in [WINDOW_DEPTH];
  logic [AW-1:0] probe;
  chain_ctl_t    ctl;

  genvar g;
  generate
    for (g = 0; g < WINDOW_DEPTH; g++) begin : g_cell
      logic [AW-1:0] upper;
      if (g == WINDOW_DEPTH - 1) begin : g_last
        assign upper = blk_r;
      end else begin : g_mid
        assign upper = cell_val[g+1];
      end
      always_comb begin
        cell_load[g] = 1'b0;
        cell_in[g]   = blk_r;
        if (ctl.pop) begin
          cell_in[g]   = (ctl.push && (DB'(g) == fill_r - DB'(1))) ? blk_r : upper;
          cell_load[g] = 1'b1;
        end else if (ctl.push && (DB'(g) == fill_r)) begin
          cell_load[g] = 1'b1;
        end
      end
      blc_cell #(.AW(AW)) u_cell (
        .clk(clk), .load(cell_load[g]), .load_val(cell_in[g]),
        .probe(probe), .value(cell_val[g]), .match(cell_match[g])
      );
    end
  endgenerate

  // Set and tag of the block under lookup.
  logic [SETB-1:0] cur_set;
  logic [TAGW-1:0] cur_tag;
  assign cur_set = (SET_COUNT > 1) ? SETB'(cur_r % SET_COUNT) : '0;
  assign cur_tag = TAGW'(cur_r / SET_COUNT);

  function automatic logic [LB-1:0] line_of(input logic [SETB-1:0] s, input logic [WB-1:0] w);
    line_of = LB'(s * WAYS + w);
  endfunction

  function automatic logic [TAGW-1:0] tag_of_way(input logic [RW-1:0] row,
                                                 input logic [WB-1:0] w);
    tag_of_way = row[TAGW*w +: TAGW];
  endfunction

  // Block held by the way under scan.
  logic [TAGW-1:0] scan_tag;
  assign scan_tag = tag_of_way(row_r, scan_way_r);
  assign probe = AW'(scan_tag * SET_COUNT + cur_set);

  // Nearest match among live cells.
  logic [DIST-1:0] near_dist;
  logic            near_found;
  always_comb begin
    near_found = 1'b0;
    near_dist  = eff_len + DIST'(1);
    for (int i = WINDOW_DEPTH - 1; i >= 0; i--) begin
      if (cell_match[i] && (DB'(i) < fill_r)) begin
        near_found = 1'b1;
        near_dist  = DIST'(i + 1);
      end
    end
  end

  // A way becomes the candidate when it is the first or lies farther ahead;
  // the scan ends at the last way or once a candidate is absent altogether.
  logic scan_take, scan_done;
  assign scan_take = !found_far_r && (scan_way_r == '0 || near_dist > far_r);
  assign scan_done = (scan_take && near_dist == eff_len + DIST'(1)) ||
                     (scan_way_r == WB'(WAYS - 1));

  // Hit search and first invalid way, from the registered tag row.
  logic          hit_c, inv_c;
  logic [WB-1:0] hway_c, iway_c;
  always_comb begin
    hit_c = 1'b0; hway_c = '0; inv_c = 1'b0; iway_c = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (valid_r[line_of(cur_set, WB'(w))] &&
          tag_of_way(row_r, WB'(w)) == cur_tag) begin
        hit_c = 1'b1; hway_c = WB'(w);
      end
      if (!valid_r[line_of(cur_set, WB'(w))]) begin
        inv_c = 1'b1; iway_c = WB'(w);
      end
    end
  end

  // Tag row update: the filled way takes the new tag, the others keep theirs.
  logic [WB-1:0] fill_way;
  logic [RW-1:0] row_wdata;
  logic          tag_we;
  assign fill_way = way_hit_r ? way_r : pick_r;
  assign tag_we   = (state_r == ST_LOOK) && !hit_r;
  always_comb begin
    row_wdata = row_r;
    row_wdata[TAGW*fill_way +: TAGW] = cur_tag;
  end

  always_ff @(posedge clk) begin
    if (tag_we) begin
      tag_mem[cur_set] <= row_wdata;
    end
    row_r <= tag_mem[cur_set];
  end

  always_comb begin
    state_nxt = state_r;
    ctl = '0;
    unique case (state_r)
      ST_IDLE:  if (start) state_nxt = ST_SHIFT;
      ST_SHIFT: begin
        ctl.pop  = look_r && !empty_r && (fill_r != '0) && !(cmd_r == CMD_ACCESS && fill_r == '0);
        ctl.push = push_r;
        if (empty_r) state_nxt = ST_EMIT;
        else if (!look_r) state_nxt = ST_IDLE;
        else state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (hit_c || inv_c || scan_done) state_nxt = ST_LOOK;
      end
      ST_LOOK:  state_nxt = ST_EMIT;
      ST_EMIT:  state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  assign busy = (state_r != ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      block_shift_r <= 4'd6;
      window_length_r <= 11'd1000;
      fill_r <= '0;
      hits_r <= '0;
      misses_r <= '0;
      valid_r <= '0;
      out_valid <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      out_valid <= (state_r == ST_EMIT);
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_IDX_W'(REG_BLOCK_SHIFT):   block_shift_r   <= cfg_wdata[3:0];
          CFG_IDX_W'(REG_WINDOW_LENGTH): window_length_r <= cfg_wdata;
          default: ;
        endcase
      end
      unique case (state_r)
        ST_IDLE: if (start) begin
          cmd_r <= in_command;
          blk_r <= AW'(in_byte_address >> block_shift_r);
          if (in_command == CMD_DRAIN) begin
            push_r <= 1'b0;
            look_r <= (fill_r != '0);
            empty_r <= (fill_r == '0);
            cur_r  <= cell_val[0];
          end else begin
            empty_r <= 1'b0;
            push_r <= !(DIST'(fill_r) >= eff_len && fill_r == '0);
            look_r <= (DIST'(fill_r) >= eff_len);
            cur_r  <= (fill_r == '0) ? AW'(in_byte_address >> block_shift_r) : cell_val[0];
          end
        end
        ST_SHIFT: begin
          if (ctl.pop && !ctl.push) fill_r <= fill_r - DB'(1);
          else if (ctl.push && !ctl.pop) fill_r <= fill_r + DB'(1);
          scan_way_r  <= '0;
          pick_r      <= '0;
          far_r       <= '0;
          found_far_r <= 1'b0;
        end
        ST_SCAN: begin
          hit_r     <= hit_c;
          way_r     <= hit_c ? hway_c : iway_c;
          way_hit_r <= hit_c || inv_c;
          if (!(hit_c || inv_c) && scan_take) begin
            far_r  <= near_dist;
            pick_r <= scan_way_r;
            if (near_dist == eff_len + DIST'(1)) found_far_r <= 1'b1;
          end
          if (scan_way_r != WB'(WAYS - 1)) scan_way_r <= scan_way_r + WB'(1);
        end
        ST_LOOK: begin
          if (!hit_r) begin
            if (!way_hit_r) way_r <= pick_r;
            valid_r[line_of(cur_set, fill_way)] <= 1'b1;
            if (misses_r != '1) misses_r <= misses_r + CNT_W'(1);
          end else if (hits_r != '1) begin
            hits_r <= hits_r + CNT_W'(1);
          end
        end
        ST_EMIT: ;
        default: ;
      endcase
    end
  end

  always_comb begin
    out_processed_block = empty_r ? '0 : 48'(cur_r);
    out_hit          = !empty_r && hit_r;
    out_way_used     = !empty_r && way_r[0];
    out_window_empty = empty_r;
    out_hit_count    = empty_r ? '0 : hits_r;
    out_miss_count   = empty_r ? '0 : misses_r;
  end

endmodule

### tb/tb_belady_lookahead_cache_unit.sv
// Self-checking testbench for the Belady lookahead cache unit.
`timescale 1ns / 1ps

module tb_belady_lookahead_cache_unit;
  import blc_pkg::*;

  localparam int SETS   = 64;
  localparam int DEPTH  = 1024;
  localparam int SETTLE = 12;   // A window-fill access may still be finishing.

  // One result of the cache, as the unit reports it.
  typedef struct {
    logic [47:0] blk;
    logic        hit;
    logic        way;
    logic        empty;
    logic [47:0] hits;
    logic [47:0] misses;
  } cache_result_t;

  // One row of the directed table; typed rows carry their own expectation.
  typedef struct {
    logic          cmd;
    logic [47:0]   addr;
    bit            typed;
    cache_result_t res;
  } directed_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  logic                  in_command;
  logic [47:0]           in_byte_address;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  out_valid;
  logic [47:0]           out_processed_block;
  logic                  out_hit;
  logic                  out_way_used;
  logic                  out_window_empty;
  logic [CNT_W-1:0]      out_hit_count;
  logic [CNT_W-1:0]      out_miss_count;

  belady_lookahead_cache_unit u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_command          (in_command),
    .in_byte_address     (in_byte_address),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .out_valid           (out_valid),
    .out_processed_block (out_processed_block),
    .out_hit             (out_hit),
    .out_way_used        (out_way_used),
    .out_window_empty    (out_window_empty),
    .out_hit_count       (out_hit_count),
    .out_miss_count      (out_miss_count)
  );

  // Shadow copy of the cache: tags, valid bits, the lookahead window (oldest
  // entry at the front), the counters and the two registers.
  logic [41:0]   tag_mem [SETS][2];
  bit            tag_ok  [SETS][2];
  logic [47:0]   lookahead_q[$];
  logic [47:0]   hits_total;
  logic [47:0]   misses_total;
  logic [3:0]    blk_shift;
  logic [10:0]   win_len;

  cache_result_t pending_results[$];
  bit            failed;
  int            burst_left;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("FAILED: results differ");
    $finish;
  end

  // The effective window length never exceeds the physical depth.
  function automatic int eff_len();
    return (win_len > DEPTH) ? DEPTH : int'(win_len);
  endfunction

  // Distance to the next use of a block: position+1, or length+1 if absent.
  // Entries beyond a lowered length still report their true distance.
  function automatic int next_use(logic [47:0] blk);
    foreach (lookahead_q[i])
      if (lookahead_q[i] == blk) return i + 1;
    return eff_len() + 1;
  endfunction

  // Way to fill on a miss: lowest invalid way, else the farthest next use.
  // A way whose block is absent from the window wins at once.
  function automatic int victim_way(int set);
    int          pick;
    int          far;
    int          d;
    logic [47:0] blk;
    pick = 0;
    far  = -1;
    for (int w = 0; w < 2; w++)
      if (!tag_ok[set][w]) return w;
    for (int w = 0; w < 2; w++) begin
      blk = {tag_mem[set][w], 6'(set)};
      d   = next_use(blk);
      if (d > far) begin
        far  = d;
        pick = w;
        if (d == eff_len() + 1) break;
      end
    end
    return pick;
  endfunction

  // Looks one block up in the shadow cache and updates it.
  function automatic cache_result_t look_up_block(logic [47:0] blk);
    cache_result_t r;
    int            set;
    int            way;
    bit            hit;
    set = int'(blk[5:0]);
    way = 0;
    hit = 0;
    for (int w = 0; w < 2; w++)
      if (!hit && tag_ok[set][w] && tag_mem[set][w] == blk[47:6]) begin
        hit = 1;
        way = w;
      end
    if (hit) begin
      if (hits_total != '1) hits_total++;
    end else begin
      if (misses_total != '1) misses_total++;
      way = victim_way(set);
      tag_mem[set][way] = blk[47:6];
      tag_ok[set][way]  = 1;
    end
    r.blk    = blk;
    r.hit    = hit;
    r.way    = way[0];
    r.empty  = 0;
    r.hits   = hits_total;
    r.misses = misses_total;
    return r;
  endfunction

  // Predicts the outcome of one accepted request; returns 1 if it yields a result.
  function automatic bit predict_request(logic cmd, logic [47:0] addr,
                                         output cache_result_t r);
    logic [47:0] blk;
    logic [47:0] oldest;
    r = '{default: '0};
    if (cmd == 1'(CMD_DRAIN)) begin
      if (lookahead_q.size() == 0) begin
        r.empty = 1;
        return 1;
      end
      oldest = lookahead_q[0];
      lookahead_q.delete(0);
      r = look_up_block(oldest);
      return 1;
    end
    blk = addr >> blk_shift;
    if (lookahead_q.size() >= eff_len()) begin
      // A zero length looks the block up at once against an empty window.
      if (lookahead_q.size() == 0) begin
        r = look_up_block(blk);
        return 1;
      end
      oldest = lookahead_q[0];
      lookahead_q.delete(0);
      lookahead_q.insert(lookahead_q.size(), blk);
      r = look_up_block(oldest);
      return 1;
    end
    lookahead_q.insert(lookahead_q.size(), blk);
    return 0;
  endfunction

  // Results come whenever the unit pleases; each is held up to the oldest
  // expectation field by field.
  always @(posedge clk) begin
    cache_result_t e;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result block=%h", $realtime, out_processed_block);
        failed = 1'b1;
      end else begin
        e = pending_results[0];
        pending_results.delete(0);
        if (out_processed_block !== e.blk) begin
          $display("%0t: processed_block expected %h actual %h",
                   $realtime, e.blk, out_processed_block);
          failed = 1'b1;
        end
        if (out_hit !== e.hit) begin
          $display("%0t: hit expected %b actual %b", $realtime, e.hit, out_hit);
          failed = 1'b1;
        end
        if (out_way_used !== e.way) begin
          $display("%0t: way_used expected %b actual %b", $realtime, e.way, out_way_used);
          failed = 1'b1;
        end
        if (out_window_empty !== e.empty) begin
          $display("%0t: window_empty expected %b actual %b",
                   $realtime, e.empty, out_window_empty);
          failed = 1'b1;
        end
        if (out_hit_count !== e.hits) begin
          $display("%0t: hit_count expected %h actual %h", $realtime, e.hits, out_hit_count);
          failed = 1'b1;
        end
        if (out_miss_count !== e.misses) begin
          $display("%0t: miss_count expected %h actual %h",
                   $realtime, e.misses, out_miss_count);
          failed = 1'b1;
        end
      end
    end
  end

  // Presents one request and holds it until the unit takes it. Start stays
  // high across a burst; between bursts the sender idles for a while.
  task automatic issue_request(logic cmd, logic [47:0] addr, bit typed,
                               cache_result_t typed_res);
    cache_result_t r;
    bit            yields;
    start           <= 1'b1;
    in_command      <= cmd;
    in_byte_address <= addr;
    do @(posedge clk); while (busy);
    yields = predict_request(cmd, addr, r);
    if (typed) pending_results.insert(pending_results.size(), typed_res);
    else if (yields) pending_results.insert(pending_results.size(), r);
    if (burst_left == 0) begin
      start      <= 1'b0;
      burst_left = $urandom_range(1, 40);
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end else begin
      burst_left--;
    end
  endtask

  // Registers change only once the unit has gone quiet.
  task automatic write_register(int idx, int value);
    @(posedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0 || busy) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_IDX_W'(idx);
    cfg_wdata <= CFG_DATA_W'(value);
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_BLOCK_SHIFT) blk_shift = value[3:0];
    else                        win_len   = value[10:0];
  endtask

  // Most addresses fall on a few blocks in a few sets, so that hits and
  // evictions are common; the rest are fully random.
  function automatic logic [47:0] pick_address();
    logic [47:0] blk;
    logic [47:0] low;
    if ($urandom_range(0, 3) != 0) begin
      blk = 48'($urandom_range(0, 5)) * SETS + 48'($urandom_range(0, 3));
      low = 48'({$urandom, $urandom});
      low = low & ((48'd1 << blk_shift) - 48'd1);
      return (blk << blk_shift) | low;
    end
    return 48'({$urandom, $urandom});
  endfunction

  task automatic run_phase(int shift, int len, int count, int drain_pct);
    logic [47:0]   addr;
    logic          cmd;
    cache_result_t none;
    none = '{default: '0};
    write_register(REG_BLOCK_SHIFT, shift);
    write_register(REG_WINDOW_LENGTH, len);
    repeat (count) begin
      cmd  = ($urandom_range(0, 99) < drain_pct) ? 1'(CMD_DRAIN) : 1'(CMD_ACCESS);
      addr = pick_address();
      issue_request(cmd, addr, 0, none);
    end
  endtask

  directed_row_t directed[];

  initial begin
    cache_result_t none;
    none            = '{default: '0};
    failed          = 0;
    burst_left      = 0;
    hits_total      = '0;
    misses_total    = '0;
    blk_shift       = 4'd6;
    win_len         = 11'd1000;
    rst_n           = 1'b0;
    start           = 1'b0;
    in_command      = 1'b0;
    in_byte_address = '0;
    cfg_we          = 1'b0;
    cfg_index       = '0;
    cfg_wdata       = '0;
    foreach (tag_ok[s, w]) tag_ok[s][w] = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // A drain straight after reset finds nothing pending.
    issue_request(1'(CMD_DRAIN), 48'hFFFF_FFFF_FFFF, 1,
                  '{48'h0, 1'b0, 1'b0, 1'b1, 48'h0, 48'h0});

    // Directed part: byte blocks, a one-entry window.
    write_register(REG_BLOCK_SHIFT, 0);
    write_register(REG_WINDOW_LENGTH, 1);
    directed = '{
      '{1'(CMD_ACCESS), 48'h0000_0000_0040, 0, none},
      '{1'(CMD_ACCESS), 48'hFFFF_FFFF_FFFF, 1,
        '{48'h0000_0000_0040, 1'b0, 1'b0, 1'b0, 48'h0, 48'h1}},
      '{1'(CMD_DRAIN),  48'h0,              1,
        '{48'hFFFF_FFFF_FFFF, 1'b0, 1'b0, 1'b0, 48'h0, 48'h2}},
      '{1'(CMD_DRAIN),  48'h0,              1,
        '{48'h0, 1'b0, 1'b0, 1'b1, 48'h0, 48'h0}},
      '{1'(CMD_ACCESS), 48'h0000_0000_0040, 0, none},
      '{1'(CMD_ACCESS), 48'h0000_0000_0040, 0, none},  // hit in way 0
      '{1'(CMD_ACCESS), 48'h0000_0000_1040, 0, none},
      '{1'(CMD_ACCESS), 48'h0000_0000_2040, 0, none},  // fills way 1
      '{1'(CMD_ACCESS), 48'h0000_0000_0040, 0, none},  // set full: evicts
      '{1'(CMD_ACCESS), 48'h0000_0000_1040, 0, none},
      '{1'(CMD_ACCESS), 48'h0000_0000_2040, 0, none},
      '{1'(CMD_ACCESS), 48'hAAAA_AAAA_AAAA, 0, none},
      '{1'(CMD_ACCESS), 48'h5555_5555_5555, 0, none},
      '{1'(CMD_ACCESS), 48'h0000_0000_0000, 0, none},
      '{1'(CMD_DRAIN),  48'h0,              0, none},
      '{1'(CMD_DRAIN),  48'h0,              0, none},
      '{1'(CMD_ACCESS), 48'hFFFF_FFFF_FFC0, 0, none},
      '{1'(CMD_ACCESS), 48'hFFFF_FFFF_F03F, 0, none},
      '{1'(CMD_DRAIN),  48'h0,              0, none}
    };
    foreach (directed[i])
      issue_request(directed[i].cmd, directed[i].addr, directed[i].typed, directed[i].res);

    // Random part over several settings, extremes among them: a zero length,
    // a length past the depth with the largest shift, and a length lowered
    // while many entries are still pending.
    run_phase(6, 4, 300, 10);
    run_phase(0, 0, 150, 10);
    run_phase(12, 16, 300, 15);
    run_phase(15, 2047, 200, 0);
    run_phase(15, 2047, 150, 100);
    run_phase(3, 32, 100, 0);
    run_phase(3, 3, 300, 20);
    run_phase(6, 1000, 150, 5);

    @(posedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE * 2) @(posedge clk);
    if (!failed) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

### filelist.f
design/blc_pkg.sv
design/blc_cell.sv
design/belady_lookahead_cache_unit.sv
tb/tb_belady_lookahead_cache_unit.sv
